// File: hdl/mait_pkg.sv
// Shared types and constants for the moving-axis interval test.
// No dependencies; used by every module of the block but mait_queue.
package mait_pkg;

    localparam int IN_BITS    = 32;
    localparam int PROD_BITS  = 2 * IN_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int DIFF_BITS  = IN_BITS + 1;
    localparam int LIMIT_BITS = 31;
    localparam int OUT_BITS   = 32;

    localparam logic [LIMIT_BITS-1:0] TIME_LIMIT_RESET = 31'd65536;

    typedef enum logic [1:0] {
        KIND_APART = 2'd0,
        KIND_HIT   = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_LAST  = 2'd3
    } kind_t;

    typedef struct packed {
        logic  start;
        kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic in_idle;
        logic in_first;
        logic in_last;
        logic div_busy;
        logic div_done;
    } back_stat_t;

endpackage

// File: hdl/mait_queue.sv
// Two-entry command queue between the front and back parts.
// No dependencies.
module mait_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_BITS-1:0] in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] out_data
);

    logic [DATA_BITS-1:0] mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/mait_front.sv
// Front part: accepts transactions, forms products, speed, case and differences.
// Depends on mait_pkg.
module mait_front #(
    parameter int FRAC_BITS  = 16,
    parameter int SPEED_BITS = 50
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [10*mait_pkg::IN_BITS-1:0]      s_tdata,
    input  logic                                 s_tuser,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output mait_pkg::cmd_t                       push_cmd,
    output logic signed [SPEED_BITS-1:0]         push_speed,
    output logic signed [mait_pkg::DIFF_BITS-1:0] push_diff_first,
    output logic signed [mait_pkg::DIFF_BITS-1:0] push_diff_last
);

    localparam int IB = mait_pkg::IN_BITS;

    logic                                  valid_reg;
    logic                                  start_reg;
    logic signed [mait_pkg::PROD_BITS-1:0] prod_reg [3];
    logic signed [IB-1:0]                  lo_a_reg, hi_a_reg, lo_b_reg, hi_b_reg;
    logic signed [mait_pkg::SUM_BITS-1:0]  sum;
    logic signed [mait_pkg::DIFF_BITS-1:0] diff_ab, diff_ba;
    logic                                  take;

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign take       = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            start_reg   <= s_tuser;
            prod_reg[0] <= $signed(s_tdata[0*IB +: IB]) * $signed(s_tdata[3*IB +: IB]);
            prod_reg[1] <= $signed(s_tdata[1*IB +: IB]) * $signed(s_tdata[4*IB +: IB]);
            prod_reg[2] <= $signed(s_tdata[2*IB +: IB]) * $signed(s_tdata[5*IB +: IB]);
            lo_a_reg    <= $signed(s_tdata[6*IB +: IB]);
            hi_a_reg    <= $signed(s_tdata[7*IB +: IB]);
            lo_b_reg    <= $signed(s_tdata[8*IB +: IB]);
            hi_b_reg    <= $signed(s_tdata[9*IB +: IB]);
        end
    end

    always_comb
    begin
        sum = mait_pkg::SUM_BITS'(prod_reg[0]) + mait_pkg::SUM_BITS'(prod_reg[1])
            + mait_pkg::SUM_BITS'(prod_reg[2])
            + (mait_pkg::SUM_BITS'(1) <<< (FRAC_BITS - 1));
        push_speed = SPEED_BITS'(sum >>> FRAC_BITS);
        diff_ab = mait_pkg::DIFF_BITS'(lo_a_reg) - mait_pkg::DIFF_BITS'(hi_b_reg);
        diff_ba = mait_pkg::DIFF_BITS'(hi_a_reg) - mait_pkg::DIFF_BITS'(lo_b_reg);
        push_cmd.start = start_reg;
        priority if (hi_b_reg < lo_a_reg)
        begin
            push_cmd.kind   = (push_speed > 0) ? mait_pkg::KIND_FULL : mait_pkg::KIND_APART;
            push_diff_first = diff_ab;
            push_diff_last  = diff_ba;
        end
        else if (hi_a_reg < lo_b_reg)
        begin
            push_cmd.kind   = (push_speed < 0) ? mait_pkg::KIND_FULL : mait_pkg::KIND_APART;
            push_diff_first = diff_ba;
            push_diff_last  = diff_ab;
        end
        else
        begin
            push_cmd.kind   = (push_speed == 0) ? mait_pkg::KIND_HIT : mait_pkg::KIND_LAST;
            push_diff_first = diff_ab;
            push_diff_last  = (push_speed > 0) ? diff_ba : diff_ab;
        end
    end

endmodule

// File: hdl/mait_div.sv
// Radix-2 restoring divider: saturated (diff * 2^FRAC_BITS) / speed, toward zero.
// Depends on mait_pkg.
module mait_div #(
    parameter int WORD_BITS  = 32,
    parameter int FRAC_BITS  = 16,
    parameter int SPEED_BITS = 50
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [mait_pkg::DIFF_BITS-1:0] diff,
    input  logic signed [SPEED_BITS-1:0]          speed,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [WORD_BITS-1:0]           quot
);

    localparam int NUM_BITS = mait_pkg::DIFF_BITS + FRAC_BITS;
    localparam int CMP_BITS = SPEED_BITS + WORD_BITS;
    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic signed [NUM_BITS-1:0]   num;
    logic [NUM_BITS-1:0]          num_mag;
    logic [SPEED_BITS-1:0]        den_mag;
    logic [NUM_BITS-1:0]          rem_reg;
    logic [CMP_BITS-1:0]          den_reg;
    logic [WORD_BITS-1:0]         q_reg;
    logic [CNT_BITS-1:0]          cnt_reg;
    logic                         busy_reg, done_reg, neg_reg, sat_reg;
    logic                         fits;

    always_comb
    begin
        num     = NUM_BITS'(diff) <<< FRAC_BITS;
        num_mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
        den_mag = speed[SPEED_BITS-1] ? SPEED_BITS'(-speed) : SPEED_BITS'(speed);
        fits    = CMP_BITS'(rem_reg) >= den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_mag;
            den_reg <= CMP_BITS'(den_mag) << (WORD_BITS - 1);
            q_reg   <= '0;
            neg_reg <= num[NUM_BITS-1] ^ speed[SPEED_BITS-1];
            sat_reg <= CMP_BITS'(num_mag) >= (CMP_BITS'(den_mag) << WORD_BITS);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= NUM_BITS'(CMP_BITS'(rem_reg) - den_reg);
            end
            q_reg   <= {q_reg[WORD_BITS-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    always_comb
    begin
        priority if (sat_reg || q_reg[WORD_BITS-1])
        begin
            quot = neg_reg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        else if (neg_reg)
        begin
            quot = -$signed(q_reg);
        end
        else
        begin
            quot = $signed(q_reg);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: hdl/mait_back.sv
// Back part: contact-time sequencer with shared divider and output register.
// Depends on mait_pkg and mait_div.
module mait_back #(
    parameter int WORD_BITS  = 32,
    parameter int FRAC_BITS  = 16,
    parameter int SPEED_BITS = 50
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  mait_pkg::cmd_t                        pop_cmd,
    input  logic signed [SPEED_BITS-1:0]          pop_speed,
    input  logic signed [mait_pkg::DIFF_BITS-1:0] pop_diff_first,
    input  logic signed [mait_pkg::DIFF_BITS-1:0] pop_diff_last,
    input  logic [mait_pkg::LIMIT_BITS-1:0]       time_limit,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [2*mait_pkg::OUT_BITS-1:0]       m_tdata,
    output logic                                  m_tuser,
    output mait_pkg::back_stat_t                  stat
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIRST = 4'b0010,
        ST_LAST  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic signed [WORD_BITS-1:0] TIME_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    state_t                                state_reg, state_next;
    logic signed [WORD_BITS-1:0]           first_reg, first_next;
    logic signed [WORD_BITS-1:0]           last_reg, last_next;
    logic                                  ok_reg, ok_next;
    logic signed [SPEED_BITS-1:0]          speed_reg;
    logic signed [mait_pkg::DIFF_BITS-1:0] diff_last_reg;
    logic                                  out_valid_reg;
    logic                                  out_ok_reg;
    logic [mait_pkg::OUT_BITS-1:0]         out_first_reg, out_last_reg;
    logic                                  div_start, div_busy, div_done;
    logic signed [mait_pkg::DIFF_BITS-1:0] div_diff;
    logic signed [SPEED_BITS-1:0]          div_speed;
    logic signed [WORD_BITS-1:0]           div_quot;
    logic signed [WORD_BITS-1:0]           first_max, last_min;
    logic                                  pop, load_out;

    mait_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SPEED_BITS(SPEED_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .diff (div_diff),
        .speed(div_speed),
        .busy (div_busy),
        .done (div_done),
        .quot (div_quot)
    );

    assign pop_ready = (state_reg == ST_IDLE);
    assign pop       = pop_valid && pop_ready;
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign first_max = (div_quot > first_reg) ? div_quot : first_reg;
    assign last_min  = (div_quot < last_reg) ? div_quot : last_reg;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        last_next  = last_reg;
        ok_next    = ok_reg;
        div_start  = 1'b0;
        div_diff   = pop_diff_first;
        div_speed  = pop_speed;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (pop_cmd.start)
                    begin
                        first_next = '0;
                        last_next  = TIME_MAX;
                    end
                    unique case (pop_cmd.kind)
                        mait_pkg::KIND_APART:
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_EMIT;
                        end
                        mait_pkg::KIND_HIT:
                        begin
                            ok_next    = 1'b1;
                            state_next = ST_EMIT;
                        end
                        mait_pkg::KIND_FULL:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_FIRST;
                        end
                        mait_pkg::KIND_LAST:
                        begin
                            div_start  = 1'b1;
                            div_diff   = pop_diff_last;
                            state_next = ST_LAST;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIRST:
            begin
                div_diff  = diff_last_reg;
                div_speed = speed_reg;
                if (div_done)
                begin
                    first_next = first_max;
                    if (64'(first_max) > $signed(64'(time_limit)))
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST:
            begin
                if (div_done)
                begin
                    last_next  = last_min;
                    ok_next    = (first_reg <= last_min);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= '0;
            last_reg      <= TIME_MAX;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            ok_reg    <= ok_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            speed_reg     <= pop_speed;
            diff_last_reg <= pop_diff_last;
        end
        if (load_out)
        begin
            out_ok_reg    <= ok_reg;
            out_first_reg <= mait_pkg::OUT_BITS'(first_reg);
            out_last_reg  <= mait_pkg::OUT_BITS'(last_reg);
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tuser       = out_ok_reg;
    assign m_tdata       = {out_last_reg, out_first_reg};
    assign stat.in_idle  = (state_reg == ST_IDLE);
    assign stat.in_first = (state_reg == ST_FIRST);
    assign stat.in_last  = (state_reg == ST_LAST);
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;

endmodule

// File: hdl/moving_axis_interval_test.sv
// Top level of the moving-axis interval test: front, command queue, back.
// Depends on mait_pkg, mait_queue, mait_front, mait_back.
//
//  channel  | dir | handshake          | contents
//  s_axis   | in  | s_tvalid/s_tready  | axis, velocity, intervals; tuser start_test
//  m_axis   | out | m_tvalid/m_tready  | first/last contact; tuser may_intersect
//  cfg      | in  | cfg_wr_en          | time_limit
//
// A transaction is registered in the front and passes the queue; the back then
// divides both, one or none of its contact times in turn on the shared radix-2
// divider and loads the result into the output register that drives m_tvalid.
// Reset clears the contact times to 0 and maximum and time_limit to 1.0.
// The two-entry queue lets the front keep accepting while the back or m_axis stalls, until it is full.
module moving_axis_interval_test #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // axis_x, axis_y, axis_z, vel_x, vel_y, vel_z, lo_a, hi_a, lo_b, hi_b
    input  logic [10*mait_pkg::IN_BITS-1:0]       s_tdata,
    // start_test
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // first_time_out, last_time_out
    output logic [2*mait_pkg::OUT_BITS-1:0]       m_tdata,
    // may_intersect
    output logic                                  m_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [mait_pkg::LIMIT_BITS-1:0]       cfg_wr_data
);

    localparam int SPEED_BITS = mait_pkg::SUM_BITS - FRAC_BITS;
    localparam int CMD_BITS   = $bits(mait_pkg::cmd_t);
    localparam int Q_BITS     = CMD_BITS + SPEED_BITS + 2 * mait_pkg::DIFF_BITS;

    logic [mait_pkg::LIMIT_BITS-1:0]       time_limit_reg;
    logic                                  f_valid, f_ready, b_valid, b_ready;
    mait_pkg::cmd_t                        f_cmd, b_cmd;
    logic signed [SPEED_BITS-1:0]          f_speed, b_speed;
    logic signed [mait_pkg::DIFF_BITS-1:0] f_first, f_last, b_first, b_last;
    logic [Q_BITS-1:0]                     q_in, q_out;
    mait_pkg::back_stat_t                  stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_limit_reg <= mait_pkg::TIME_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            time_limit_reg <= cfg_wr_data;
        end
    end

    mait_front #(
        .FRAC_BITS (FRAC_BITS),
        .SPEED_BITS(SPEED_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .push_valid     (f_valid),
        .push_ready     (f_ready),
        .push_cmd       (f_cmd),
        .push_speed     (f_speed),
        .push_diff_first(f_first),
        .push_diff_last (f_last)
    );

    assign q_in = {f_cmd, f_speed, f_first, f_last};
    assign {b_cmd, b_speed, b_first, b_last} = q_out;

    mait_queue #(
        .DATA_BITS(Q_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (q_in),
        .out_valid(b_valid),
        .out_ready(b_ready),
        .out_data (q_out)
    );

    mait_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .SPEED_BITS(SPEED_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (b_valid),
        .pop_ready     (b_ready),
        .pop_cmd       (b_cmd),
        .pop_speed     (b_speed),
        .pop_diff_first(b_first),
        .pop_diff_last (b_last),
        .time_limit    (time_limit_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .stat          (stat)
    );

`ifndef SYNTHESIS
    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (stat.in_first || stat.in_last))
        else $error("divider result outside a division state");

    a_busy_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_busy |-> !stat.in_idle)
        else $error("divider busy while sequencer idle");

    a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!stat.in_idle && !stat.in_first && !stat.in_last))
        else $error("result raised outside emit");
`endif

endmodule
